// File: rtl/sra_pkg.sv
// ----------------------------------------------------------------------------
// sra_pkg
// Shared types and constants of the slot allocator with reuse delay.
// ----------------------------------------------------------------------------
package sra_pkg;

    localparam int CNT_W      = 11;   // cursor and used count
    localparam int SLOT_W     = 10;   // slot number on the ports
    localparam int TIME_W     = 32;
    localparam int DLY_W      = 16;
    localparam int CLI_W      = 8;
    localparam int BODY_W     = 6;
    localparam int MODE_W     = 2;
    localparam int STAT_W     = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int ENTRY_W    = 1 + TIME_W;

    // config reset values
    localparam logic [CLI_W-1:0]  RST_CLIENT_SLOTS = 8'd8;
    localparam logic [BODY_W-1:0] RST_BODY_SLOTS   = 6'd8;
    localparam logic [CNT_W-1:0]  RST_SLOT_LIMIT   = 11'd1024;
    localparam logic [DLY_W-1:0]  RST_REUSE_DELAY  = 16'd500;
    localparam logic [DLY_W-1:0]  RST_EARLY_WINDOW = 16'd2000;

    // bookkeeping reset values, taken from the reset client count
    localparam logic [CNT_W-1:0]  RST_USED_COUNT   = 11'd9;
    localparam logic [CNT_W-1:0]  RST_CURSOR       = 11'd8;

    typedef enum logic [MODE_W-1:0] {
        MODE_ALLOC    = 2'd0,
        MODE_FREE     = 2'd1,
        MODE_BOOKMARK = 2'd2,
        MODE_UNUSED   = 2'd3
    } mode_t;

    typedef enum logic [STAT_W-1:0] {
        ST_ALLOC   = 3'd0,
        ST_FREED   = 3'd1,
        ST_IGNORED = 3'd2,
        ST_FULL    = 3'd3,
        ST_RESET   = 3'd4
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CLIENT_SLOTS = 3'd0,
        CFG_BODY_SLOTS   = 3'd1,
        CFG_SLOT_LIMIT   = 3'd2,
        CFG_REUSE_DELAY  = 3'd3,
        CFG_EARLY_WINDOW = 3'd4
    } cfg_idx_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ALLOC,
        S_SCAN,
        S_GROW,
        S_FREE,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        status_t           status;
    } result_t;

    typedef struct packed {
        logic              used;
        logic [TIME_W-1:0] stamp;
    } entry_t;

endpackage

// File: rtl/sra_if.sv
// ----------------------------------------------------------------------------
// sra_if
// Request, response and configuration channels of the slot allocator.
// ----------------------------------------------------------------------------
interface sra_req_if;
    import sra_pkg::*;

    logic                valid;
    logic                ready;
    logic [MODE_W-1:0]   mode;
    logic [SLOT_W-1:0]   slot_index;
    logic [TIME_W-1:0]   now_ms;

    modport source (output valid, output mode, output slot_index, output now_ms,
                    input ready);
    modport sink   (input valid, input mode, input slot_index, input now_ms,
                    output ready);
endinterface

interface sra_rsp_if;
    import sra_pkg::*;

    logic                valid;
    logic                ready;
    logic [SLOT_W-1:0]   slot_index_out;
    logic [STAT_W-1:0]   status;

    modport source (output valid, output slot_index_out, output status,
                    input ready);
    modport sink   (input valid, input slot_index_out, input status,
                    output ready);
endinterface

interface sra_cfg_if;
    import sra_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/slot_allocator_reuse_delay.sv
// ----------------------------------------------------------------------------
// slot_allocator_reuse_delay
// Slot allocator with reuse delay: per-slot used bit and free time in one RAM,
// forward search cursor, high-water count and one remembered freed slot.
// ----------------------------------------------------------------------------
//  Channel  Role   Handshake    Payload
//  cfg      sink   valid/ready  index, data (register write, always ready)
//  req      sink   valid/ready  mode, slot_index, now_ms
//  rsp      source valid/ready  slot_index_out, status
//
//  One request at a time. From accept to response register: bookmark reset
//  and unused mode go straight to S_FINISH; free passes S_FREE; an allocation
//  served by the remembered slot passes S_ALLOC; a scanning allocation passes
//  S_ALLOC and S_SCAN (one RAM read per cycle from the cursor up to the used
//  count), then S_GROW if it grows or runs out; the next accept is in S_IDLE.
//  After reset a clearing pass writes all SLOTS entries, one per cycle, while
//  req.ready stays low; cfg writes are taken throughout.
//  A stalled response sits in the output register; the next request is taken
//  and worked on, and waits only at its own hand-off.
// ----------------------------------------------------------------------------
module slot_allocator_reuse_delay #(
    parameter int SLOTS = 1024
) (
    input  logic      clk,
    input  logic      rst_n,
    sra_cfg_if.sink   cfg,
    sra_req_if.sink   req,
    sra_rsp_if.source rsp
);
    import sra_pkg::*;

    localparam int          AW      = $clog2(SLOTS);
    localparam int          XW      = AW + CNT_W;
    localparam logic [31:0] SLOTS_U = 32'(SLOTS);
    localparam logic [AW-1:0] LAST_ADDR = AW'(SLOTS - 1);

    // configuration
    logic [CLI_W-1:0]  client_slots_reg;
    logic [BODY_W-1:0] body_slots_reg;
    logic [CNT_W-1:0]  slot_limit_reg;
    logic [DLY_W-1:0]  reuse_delay_reg;
    logic [DLY_W-1:0]  early_window_reg;

    // control state
    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  cursor_reg, cursor_next;
    logic [CNT_W-1:0]  used_count_reg, used_count_next;
    logic              held_valid_reg, held_valid_next;
    logic [CNT_W-1:0]  held_slot_reg, held_slot_next;
    logic [TIME_W-1:0] held_time_reg, held_time_next;
    logic              rd_valid_reg, rd_valid_next;
    logic [AW-1:0]     clr_idx_reg, clr_idx_next;

    // current request and its result
    mode_t             mode_reg;
    logic [SLOT_W-1:0] slot_in_reg;
    logic [TIME_W-1:0] now_reg;
    result_t           res_reg, res_next;

    // RAM port
    logic              ram_we, ram_re;
    logic [AW-1:0]     ram_waddr, ram_raddr;
    entry_t            ram_wdata;
    logic [ENTRY_W-1:0] ram_rdata;
    entry_t            rd_entry;

    logic              out_ready, push;
    logic              accept;

    // predicates
    logic [CNT_W-1:0]  cur_inc;
    logic [CNT_W-1:0]  free_slot_ext;
    logic              early, held_hit, scan_ok_cur, scan_ok_inc;
    logic              cand_free, cand_fit, found, full;
    logic              free_in_range, protected_slot, free_ok;

    function automatic logic [AW-1:0] to_addr(input logic [CNT_W-1:0] v);
        logic [XW-1:0] ext;
        ext = {{AW{1'b0}}, v};
        return ext[AW-1:0];
    endfunction

    function automatic logic rested(input logic [TIME_W-1:0] now,
                                    input logic [TIME_W-1:0] stamp,
                                    input logic [DLY_W-1:0]  dly);
        logic [TIME_W-1:0] age;
        age = now - stamp;
        return age > {{(TIME_W-DLY_W){1'b0}}, dly};
    endfunction

    function automatic logic in_scan(input logic [CNT_W-1:0] c,
                                     input logic [CNT_W-1:0] cnt);
        return (c < cnt) && (32'(c) < SLOTS_U);
    endfunction

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            client_slots_reg <= RST_CLIENT_SLOTS;
            body_slots_reg   <= RST_BODY_SLOTS;
            slot_limit_reg   <= RST_SLOT_LIMIT;
            reuse_delay_reg  <= RST_REUSE_DELAY;
            early_window_reg <= RST_EARLY_WINDOW;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_CLIENT_SLOTS: client_slots_reg <= cfg.data[CLI_W-1:0];
                CFG_BODY_SLOTS:   body_slots_reg   <= cfg.data[BODY_W-1:0];
                CFG_SLOT_LIMIT:   slot_limit_reg   <= cfg.data[CNT_W-1:0];
                CFG_REUSE_DELAY:  reuse_delay_reg  <= cfg.data[DLY_W-1:0];
                CFG_EARLY_WINDOW: early_window_reg <= cfg.data[DLY_W-1:0];
                default:          ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // predicates
    // ------------------------------------------------------------------
    assign accept        = req.valid && req.ready;
    assign rd_entry      = entry_t'(ram_rdata);
    assign cur_inc       = cursor_reg + 1'b1;
    assign free_slot_ext = {1'b0, slot_in_reg};

    assign early       = now_reg < {{(TIME_W-DLY_W){1'b0}}, early_window_reg};
    assign held_hit    = held_valid_reg
                         && (early || rested(now_reg, held_time_reg, reuse_delay_reg));
    assign scan_ok_cur = in_scan(cursor_reg, used_count_reg);
    assign scan_ok_inc = in_scan(cur_inc, used_count_reg);
    assign cand_free   = !rd_entry.used;
    assign cand_fit    = early || rested(now_reg, rd_entry.stamp, reuse_delay_reg);
    assign found       = rd_valid_reg && cand_free && cand_fit;
    assign full        = (used_count_reg >= slot_limit_reg)
                         || (32'(used_count_reg) >= SLOTS_U);

    assign free_in_range  = 32'(slot_in_reg) < SLOTS_U;
    assign protected_slot = free_slot_ext
                            <= (CNT_W'(client_slots_reg) + CNT_W'(body_slots_reg));
    assign free_ok        = free_in_range && rd_entry.used && !protected_slot;

    // ------------------------------------------------------------------
    // next state and bookkeeping
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next      = state_reg;
        cursor_next     = cursor_reg;
        used_count_next = used_count_reg;
        held_valid_next = held_valid_reg;
        held_slot_next  = held_slot_reg;
        held_time_next  = held_time_reg;
        rd_valid_next   = 1'b0;
        clr_idx_next    = clr_idx_reg;
        res_next        = res_reg;

        unique case (state_reg)
            S_CLEAR:
            begin
                clr_idx_next = clr_idx_reg + 1'b1;
                if (clr_idx_reg == LAST_ADDR)
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (req.valid)
                begin
                    unique case (mode_t'(req.mode))
                        MODE_ALLOC: state_next = S_ALLOC;
                        MODE_FREE:  state_next = S_FREE;
                        MODE_BOOKMARK:
                        begin
                            cursor_next     = CNT_W'(client_slots_reg);
                            held_valid_next = 1'b0;
                            res_next        = '{slot: '0, status: ST_RESET};
                            state_next      = S_FINISH;
                        end
                        MODE_UNUSED:
                        begin
                            res_next   = '{slot: '0, status: ST_IGNORED};
                            state_next = S_FINISH;
                        end
                    endcase
                end
            end

            S_ALLOC:
            begin
                if (held_hit)
                begin
                    held_valid_next = 1'b0;
                    if (cursor_reg > held_slot_reg)
                    begin
                        cursor_next = held_slot_reg;
                    end
                    res_next   = '{slot: held_slot_reg[SLOT_W-1:0], status: ST_ALLOC};
                    state_next = S_FINISH;
                end
                else
                begin
                    cursor_next = cur_inc;
                    state_next  = S_SCAN;
                end
            end

            S_SCAN:
            begin
                // memory output belongs to cursor_reg when rd_valid_reg is set
                if (rd_valid_reg)
                begin
                    if (found)
                    begin
                        res_next   = '{slot: cursor_reg[SLOT_W-1:0], status: ST_ALLOC};
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        if (cand_free && !held_valid_reg)
                        begin
                            held_valid_next = 1'b1;
                            held_slot_next  = cursor_reg;
                            held_time_next  = rd_entry.stamp;
                        end
                        cursor_next = cur_inc;
                        if (scan_ok_inc)
                        begin
                            rd_valid_next = 1'b1;
                        end
                        else
                        begin
                            state_next = S_GROW;
                        end
                    end
                end
                else if (scan_ok_cur)
                begin
                    rd_valid_next = 1'b1;
                end
                else
                begin
                    state_next = S_GROW;
                end
            end

            S_GROW:
            begin
                if (full)
                begin
                    res_next = '{slot: '0, status: ST_FULL};
                end
                else
                begin
                    used_count_next = used_count_reg + 1'b1;
                    cursor_next     = used_count_reg;
                    res_next = '{slot: used_count_reg[SLOT_W-1:0], status: ST_ALLOC};
                end
                state_next = S_FINISH;
            end

            S_FREE:
            begin
                if (free_ok)
                begin
                    if (!held_valid_reg || (free_slot_ext < held_slot_reg))
                    begin
                        held_valid_next = 1'b1;
                        held_slot_next  = free_slot_ext;
                        held_time_next  = now_reg;
                    end
                    res_next = '{slot: slot_in_reg, status: ST_FREED};
                end
                else
                begin
                    res_next = '{slot: slot_in_reg, status: ST_IGNORED};
                end
                state_next = S_FINISH;
            end

            S_FINISH:
            begin
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // outputs: handshake and RAM port
    // ------------------------------------------------------------------
    always_comb
    begin
        req.ready = 1'b0;
        push      = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = clr_idx_reg;
        ram_wdata = '{used: 1'b0, stamp: '0};
        ram_re    = 1'b0;
        ram_raddr = to_addr(cursor_reg);

        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we = 1'b1;
            end

            S_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid && (mode_t'(req.mode) == MODE_FREE))
                begin
                    ram_re    = 1'b1;
                    ram_raddr = to_addr({1'b0, req.slot_index});
                end
            end

            S_ALLOC:
            begin
                if (held_hit)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = to_addr(held_slot_reg);
                    ram_wdata = '{used: 1'b1, stamp: '0};
                end
            end

            S_SCAN:
            begin
                if (found)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = to_addr(cursor_reg);
                    ram_wdata = '{used: 1'b1, stamp: '0};
                end
                else if (rd_valid_reg)
                begin
                    ram_re    = scan_ok_inc;
                    ram_raddr = to_addr(cur_inc);
                end
                else
                begin
                    ram_re = scan_ok_cur;
                end
            end

            S_GROW:
            begin
                if (!full)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = to_addr(used_count_reg);
                    ram_wdata = '{used: 1'b1, stamp: '0};
                end
            end

            S_FREE:
            begin
                if (free_ok)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = to_addr(free_slot_ext);
                    ram_wdata = '{used: 1'b0, stamp: now_reg};
                end
            end

            S_FINISH:
            begin
                push = 1'b1;
            end

            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            cursor_reg     <= RST_CURSOR;
            used_count_reg <= RST_USED_COUNT;
            held_valid_reg <= 1'b0;
            held_slot_reg  <= '0;
            held_time_reg  <= '0;
            rd_valid_reg   <= 1'b0;
            clr_idx_reg    <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            cursor_reg     <= cursor_next;
            used_count_reg <= used_count_next;
            held_valid_reg <= held_valid_next;
            held_slot_reg  <= held_slot_next;
            held_time_reg  <= held_time_next;
            rd_valid_reg   <= rd_valid_next;
            clr_idx_reg    <= clr_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg    <= mode_t'(req.mode);
            slot_in_reg <= req.slot_index;
            now_reg     <= req.now_ms;
        end
        res_reg <= res_next;
    end

    // ------------------------------------------------------------------
    // state RAM and response register
    // ------------------------------------------------------------------
    sra_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOTS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    sra_out_buf u_out_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_res   (res_reg),
        .push_ready (out_ready),
        .rsp        (rsp)
    );

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_rw_same_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
        else $error("RAM read and write hit the same entry");

    a_held_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        held_valid_reg |-> (32'(held_slot_reg) < SLOTS_U))
        else $error("remembered slot outside the slot table");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(used_count_reg) <= SLOTS_U)
        else $error("used count beyond slot table");

    a_finish_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FINISH && !out_ready) |=> (state_reg == S_FINISH))
        else $error("result left before the response register took it");

    a_free_mode: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FREE) |-> (mode_reg == MODE_FREE))
        else $error("free evaluation without a free request");

endmodule

// File: rtl/sra_ram.sv
// ----------------------------------------------------------------------------
// sra_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sra_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/sra_out_buf.sv
// ----------------------------------------------------------------------------
// sra_out_buf
// One-entry response register between the allocator core and the response
// channel; the core can take the next request while a response waits.
// ----------------------------------------------------------------------------
module sra_out_buf (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  sra_pkg::result_t push_res,
    output logic             push_ready,
    sra_rsp_if.source        rsp
);
    import sra_pkg::*;

    logic    full_reg;
    logic    full_next;
    result_t data_reg;

    assign push_ready = !full_reg || rsp.ready;
    assign full_next  = push || (full_reg && !rsp.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
        end
        else
        begin
            full_reg <= full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && push_ready)
        begin
            data_reg <= push_res;
        end
    end

    assign rsp.valid          = full_reg;
    assign rsp.slot_index_out = data_reg.slot;
    assign rsp.status         = data_reg.status;

    // a stalled response keeps its valid and its payload
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (full_reg && !rsp.ready) |=> full_reg)
        else $error("response dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        (full_reg && !rsp.ready) |=> $stable(data_reg))
        else $error("response payload changed while stalled");

    a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (push && push_ready) |=> full_reg)
        else $error("pushed response not held");

endmodule

// File: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for slot_allocator_reuse_delay. A behavioral copy of the
// allocator (used bits, free stamps, cursor, used count, held slot) predicts
// the response to every accepted request; a monitor compares each response
// field by field, in order. Directed requests cover the corner cases, then
// random traffic runs under several register settings and handshake stalls,
// finishing with a fill of all slots up to the out-of-slots condition.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import sra_pkg::*;

    localparam int SLOTS = 1024;
    // ~2k requests, each worst case a full scan plus stalls, taken ~3x over
    localparam int LIMIT = 6_000_000;

    logic clk = 1'b0;
    logic rst_n;

    sra_cfg_if cfg_ch ();
    sra_req_if req_ch ();
    sra_rsp_if rsp_ch ();

    slot_allocator_reuse_delay #(
        .SLOTS (SLOTS)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always #5 clk = ~clk;

    // allocator copy
    bit               slot_busy [SLOTS];
    logic [TIME_W-1:0] slot_stamp [SLOTS];
    logic [CNT_W-1:0] used_cnt;
    logic [CNT_W-1:0] cursor;
    bit               hold_vld;
    logic [SLOT_W-1:0] hold_slot;
    logic [TIME_W-1:0] hold_stamp;

    logic [CLI_W-1:0]  cfg_clients;
    logic [BODY_W-1:0] cfg_body;
    logic [CNT_W-1:0]  cfg_limit;
    logic [DLY_W-1:0]  reuse_delay;
    logic [DLY_W-1:0]  early_window;

    result_t pending_rsp [$];
    result_t head_rsp;

    logic [TIME_W-1:0] wall_ms;
    int snd_idle_pct  = 0;
    int rcv_stall_pct = 0;
    int cycle_count   = 0;
    int err_count     = 0;
    int req_count     = 0;
    int rsp_count     = 0;
    int setting_count = 0;
    int peak_used     = 0;
    int n_grant = 0, n_freed = 0, n_ignored = 0, n_full = 0, n_bookmark = 0;

    function automatic void init_model();
        for (int k = 0; k < SLOTS; k++)
        begin
            slot_busy[k]  = 1'b0;
            slot_stamp[k] = '0;
        end
        cfg_clients  = RST_CLIENT_SLOTS;
        cfg_body     = RST_BODY_SLOTS;
        cfg_limit    = RST_SLOT_LIMIT;
        reuse_delay  = RST_REUSE_DELAY;
        early_window = RST_EARLY_WINDOW;
        used_cnt     = RST_USED_COUNT;
        cursor       = RST_CURSOR;
        hold_vld     = 1'b0;
        hold_slot    = '0;
        hold_stamp   = '0;
    endfunction

    function automatic void apply_config(input cfg_idx_t idx,
                                         input logic [CFG_DATA_W-1:0] val);
        unique case (idx)
            CFG_CLIENT_SLOTS: cfg_clients  = val[CLI_W-1:0];
            CFG_BODY_SLOTS:   cfg_body     = val[BODY_W-1:0];
            CFG_SLOT_LIMIT:   cfg_limit    = val[CNT_W-1:0];
            CFG_REUSE_DELAY:  reuse_delay  = val;
            CFG_EARLY_WINDOW: early_window = val;
            default: ;
        endcase
    endfunction

    // age is an unsigned 32-bit difference, so a stamp "in the future" looks very old
    function automatic bit has_rested(input logic [TIME_W-1:0] now,
                                      input logic [TIME_W-1:0] stamp);
        logic [TIME_W-1:0] age;
        age = now - stamp;
        return age > {16'd0, reuse_delay};
    endfunction

    function automatic result_t predict_grant(input logic [TIME_W-1:0] now);
        result_t          r;
        bit               early;
        logic [CNT_W-1:0] grown;
        early    = now < {16'd0, early_window};
        r.slot   = '0;
        r.status = ST_ALLOC;
        if (hold_vld && (early || has_rested(now, hold_stamp)))
        begin
            hold_vld = 1'b0;
            if (cursor > {1'b0, hold_slot})
                cursor = {1'b0, hold_slot};
            slot_busy[hold_slot] = 1'b1;
            r.slot = hold_slot;
            return r;
        end
        cursor = cursor + 1'b1;
        while (cursor < used_cnt && cursor < SLOTS)
        begin
            if (!slot_busy[cursor])
            begin
                if (early || has_rested(now, slot_stamp[cursor]))
                begin
                    slot_busy[cursor] = 1'b1;
                    r.slot = cursor[SLOT_W-1:0];
                    return r;
                end
                if (!hold_vld)
                begin
                    hold_slot  = cursor[SLOT_W-1:0];
                    hold_stamp = slot_stamp[cursor];
                    hold_vld   = 1'b1;
                end
            end
            cursor = cursor + 1'b1;
        end
        if (used_cnt >= cfg_limit || used_cnt >= SLOTS)
        begin
            r.status = ST_FULL;
            return r;
        end
        grown    = used_cnt;
        used_cnt = used_cnt + 1'b1;
        cursor   = grown;
        slot_busy[grown] = 1'b1;
        if (int'(used_cnt) > peak_used)
            peak_used = int'(used_cnt);
        r.slot = grown[SLOT_W-1:0];
        return r;
    endfunction

    function automatic result_t predict_release(input logic [SLOT_W-1:0] idx,
                                                input logic [TIME_W-1:0] now);
        result_t r;
        r.slot   = idx;
        r.status = ST_IGNORED;
        if (!slot_busy[idx])
            return r;
        if (int'(idx) <= int'(cfg_clients) + int'(cfg_body))
            return r;
        slot_busy[idx]  = 1'b0;
        slot_stamp[idx] = now;
        if (!hold_vld || idx < hold_slot)
        begin
            hold_slot  = idx;
            hold_stamp = now;
            hold_vld   = 1'b1;
        end
        r.status = ST_FREED;
        return r;
    endfunction

    function automatic result_t predict_response(input mode_t m,
                                                 input logic [SLOT_W-1:0] idx,
                                                 input logic [TIME_W-1:0] now);
        result_t r;
        r.slot   = '0;
        r.status = ST_IGNORED;
        unique case (m)
            MODE_ALLOC: r = predict_grant(now);
            MODE_FREE:  r = predict_release(idx, now);
            MODE_BOOKMARK:
            begin
                cursor   = {3'd0, cfg_clients};
                hold_vld = 1'b0;
                r.status = ST_RESET;
            end
            default: ;
        endcase
        return r;
    endfunction

    // a slot that is in use, when one turns up in a few tries
    function automatic logic [SLOT_W-1:0] pick_busy_slot();
        int c;
        c = 0;
        for (int t = 0; t < 16; t++)
        begin
            c = $urandom_range(0, int'(used_cnt) - 1);
            if (c < SLOTS && slot_busy[c])
                return c[SLOT_W-1:0];
        end
        return c[SLOT_W-1:0];
    endfunction

    function automatic logic [SLOT_W-1:0] any_slot();
        return SLOT_W'($urandom_range(0, SLOTS - 1));
    endfunction

    // valid stays high between back-to-back requests; it drops only for a gap
    task automatic issue(input mode_t m, input logic [SLOT_W-1:0] idx,
                         input logic [TIME_W-1:0] now);
        if (snd_idle_pct != 0 && $urandom_range(0, 99) < snd_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(0, 99) < snd_idle_pct);
        end
        req_ch.valid      <= 1'b1;
        req_ch.mode       <= m;
        req_ch.slot_index <= idx;
        req_ch.now_ms     <= now;
        do @(posedge clk); while (!req_ch.ready);
        pending_rsp.insert(pending_rsp.size(), predict_response(m, idx, now));
        req_count++;
    endtask

    task automatic drain();
        req_ch.valid <= 1'b0;
        while (pending_rsp.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_config(input logic [CLI_W-1:0] clients,
                                input logic [BODY_W-1:0] body,
                                input logic [CNT_W-1:0] limit, input logic [DLY_W-1:0] delay,
                                input logic [DLY_W-1:0] early);
        logic [CFG_DATA_W-1:0] vals [5];
        cfg_idx_t              idx;
        drain();
        vals[0] = {8'd0, clients};
        vals[1] = {10'd0, body};
        vals[2] = {5'd0, limit};
        vals[3] = delay;
        vals[4] = early;
        idx = CFG_CLIENT_SLOTS;
        for (int k = 0; k < 5; k++)
        begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= idx;
            cfg_ch.data  <= vals[k];
            do @(posedge clk); while (!cfg_ch.ready);
            apply_config(idx, vals[k]);
            idx = idx.next();
        end
        cfg_ch.valid <= 1'b0;
        setting_count++;
    endtask

    task automatic set_idling(input int snd_pct, input int rcv_pct);
        snd_idle_pct  = snd_pct;
        rcv_stall_pct = rcv_pct;
    endtask

    // mostly well-formed alloc/free traffic on a moving clock, some noise
    task automatic run_traffic(input int n, input int alloc_pct, input int jump_pct);
        int                roll;
        int                step_roll;
        logic [TIME_W-1:0] now;
        for (int k = 0; k < n; k++)
        begin
            roll      = $urandom_range(0, 99);
            step_roll = $urandom_range(0, 99);
            if (step_roll < jump_pct)
                wall_ms = wall_ms + $urandom;
            else if (step_roll < 50)
                wall_ms = wall_ms + $urandom_range(0, 40);
            else if (step_roll < 85)
                wall_ms = wall_ms + $urandom_range(0, 700);
            else
                wall_ms = wall_ms + $urandom_range(0, 3000);
            now = wall_ms;
            if ($urandom_range(0, 99) < jump_pct)
                now = $urandom;
            if (roll < alloc_pct)
                issue(MODE_ALLOC, any_slot(), now);
            else if (roll < 92)
                issue(MODE_FREE, pick_busy_slot(), now);
            else if (roll < 96)
                issue(MODE_FREE, any_slot(), now);
            else if (roll < 98)
                issue(MODE_BOOKMARK, any_slot(), now);
            else
                issue(MODE_UNUSED, any_slot(), now);
        end
    endtask

    task automatic test_grant_and_release();
        set_idling(0, 0);
        write_config(8'd1, 6'd0, 11'd1024, 16'd500, 16'd2000);
        issue(MODE_ALLOC, 10'd0, 32'd0);
        issue(MODE_ALLOC, 10'd0, 32'd0);
        issue(MODE_FREE, 10'd10, 32'd100);
        issue(MODE_FREE, 10'd10, 32'd150);            // already free
        issue(MODE_ALLOC, 10'd0, 32'd300);            // early window reuses the held slot
        issue(MODE_FREE, 10'd10, 32'd3000);
        issue(MODE_ALLOC, 10'd0, 32'd3100);           // held slot too recent, grows
        issue(MODE_ALLOC, 10'd0, 32'd3501);           // held slot now rested
        issue(MODE_FREE, 10'd0, 32'd0);
        issue(MODE_FREE, 10'd1023, 32'hFFFF_FFFF);
        issue(MODE_UNUSED, 10'd1023, 32'hFFFF_FFFF);
        issue(MODE_BOOKMARK, 10'd0, 32'd0);
        issue(MODE_ALLOC, 10'd1023, 32'hFFFF_FFFF);   // scan from the client boundary
    endtask

    task automatic test_register_extremes();
        write_config(8'd255, 6'd63, 11'd1, 16'd65535, 16'd65535);
        issue(MODE_FREE, 10'd9, 32'd5);               // protected slot stays in use
        issue(MODE_BOOKMARK, 10'd0, 32'd0);           // cursor lands beyond the used count
        issue(MODE_ALLOC, 10'd0, 32'd70000);          // out of slots
        write_config(8'd1, 6'd0, 11'd1024, 16'd65535, 16'd0);
        issue(MODE_ALLOC, 10'd0, 32'd10);
        issue(MODE_FREE, 10'd12, 32'd10);
        issue(MODE_ALLOC, 10'd0, 32'd65545);          // age equals delay: not rested
        issue(MODE_ALLOC, 10'd0, 32'd65546);
        write_config(8'd1, 6'd0, 11'd1024, 16'd0, 16'd0);
        issue(MODE_FREE, 10'd13, 32'd7);
        issue(MODE_ALLOC, 10'd0, 32'd7);
        issue(MODE_ALLOC, 10'd0, 32'd8);
    endtask

    task automatic test_mixed_traffic();
        set_idling(0, 0);
        write_config(8'd8, 6'd8, 11'd64, 16'd500, 16'd2000);
        wall_ms = '0;
        run_traffic(180, 55, 0);

        set_idling(55, 0);
        write_config(8'd1, 6'd0, 11'd128, 16'd0, 16'd0);
        wall_ms = $urandom;
        run_traffic(180, 50, 3);

        set_idling(0, 55);
        write_config(8'd20, 6'd63, 11'd200, 16'd300, 16'd65535);
        wall_ms = '0;
        run_traffic(180, 55, 0);

        set_idling(24, 24);
        write_config(CLI_W'($urandom_range(1, 40)), BODY_W'($urandom_range(0, 63)),
                     CNT_W'($urandom_range(100, 400)), DLY_W'($urandom_range(0, 65535)),
                     DLY_W'($urandom_range(0, 65535)));
        wall_ms = $urandom_range(0, 65535);
        run_traffic(180, 55, 2);

        set_idling(0, 0);
        write_config(8'd255, 6'd63, 11'd400, 16'd1000, 16'd3000);
        wall_ms = '0;
        run_traffic(180, 50, 1);
    endtask

    // long reuse delay keeps freed slots parked, so the count climbs to the limit
    task automatic test_fill_to_limit();
        set_idling(24, 24);
        write_config(8'd8, 6'd8, 11'd1024, 16'd65535, 16'd0);
        wall_ms = $urandom;
        run_traffic(1050, 80, 3);
    endtask

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    always @(posedge clk)
        rsp_ch.ready <= ($urandom_range(0, 99) >= rcv_stall_pct);

    always @(posedge clk)
    begin
        if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
        begin
            rsp_count++;
            if (pending_rsp.size() == 0)
            begin
                $error("response with no request pending: slot_index_out %0d, status %0d",
                       rsp_ch.slot_index_out, rsp_ch.status);
                err_count++;
            end
            else
            begin
                head_rsp = pending_rsp.pop_front();
                if (rsp_ch.slot_index_out !== head_rsp.slot)
                begin
                    $error("slot_index_out: expected %0d, actual %0d",
                           head_rsp.slot, rsp_ch.slot_index_out);
                    err_count++;
                end
                if (rsp_ch.status !== head_rsp.status)
                begin
                    $error("status: expected %0d, actual %0d", head_rsp.status, rsp_ch.status);
                    err_count++;
                end
                unique case (head_rsp.status)
                    ST_ALLOC:   n_grant++;
                    ST_FREED:   n_freed++;
                    ST_IGNORED: n_ignored++;
                    ST_FULL:    n_full++;
                    ST_RESET:   n_bookmark++;
                    default: ;
                endcase
            end
        end
    end

    initial
    begin
        while (cycle_count < LIMIT) @(posedge clk);
        $error("timeout after %0d cycles with %0d responses outstanding",
               cycle_count, pending_rsp.size());
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        init_model();
        peak_used         = int'(RST_USED_COUNT);
        wall_ms           = '0;
        rst_n             <= 1'b0;
        cfg_ch.valid      <= 1'b0;
        cfg_ch.index      <= CFG_CLIENT_SLOTS;
        cfg_ch.data       <= '0;
        req_ch.valid      <= 1'b0;
        req_ch.mode       <= MODE_ALLOC;
        req_ch.slot_index <= '0;
        req_ch.now_ms     <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        test_grant_and_release();
        test_register_extremes();
        test_mixed_traffic();
        test_fill_to_limit();

        drain();
        repeat (32) @(posedge clk);

        $display("%0d requests checked under %0d register settings, peak used count %0d",
                 rsp_count, setting_count, peak_used);
        $display("granted %0d, freed %0d, ignored %0d, out of slots %0d, bookmark resets %0d",
                 n_grant, n_freed, n_ignored, n_full, n_bookmark);
        if (err_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
